@@ rtl/qle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qle_pkg - shared types and helpers for the quorum leader election block
// Item layout, stream widths, configuration bundle, popcount helper.
// ----------------------------------------------------------------------------
package qle_pkg;

    localparam int MAX_FOLLOWERS = 32;
    localparam int SLOT_W        = 6;
    localparam int TERM_W        = 31;
    localparam int S_DATA_W      = 48;
    localparam int M_DATA_W      = 56;

    localparam logic [SLOT_W-1:0] UNREG_SLOT    = 6'd32;
    localparam logic [SLOT_W-1:0] MAX_COUNT     = 6'd32;
    localparam logic [TERM_W-1:0] TERM_MAX      = {TERM_W{1'b1}};

    // Configuration register indexes
    localparam logic REG_FOLLOWER_COUNT = 1'b0;
    localparam logic REG_SELF_INDEX     = 1'b1;

    // Request types on the input tuser bit
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_BALLOT = 1'b1;

    // Classified request kinds
    typedef enum logic [1:0] {
        KIND_TICK_HEALTHY = 2'd0,
        KIND_TICK_FAILED  = 2'd1,
        KIND_BALLOT       = 2'd2
    } kind_t;

    // Effective configuration, already clamped and normalized
    typedef struct packed {
        logic [SLOT_W-1:0] count;   // 1..32
        logic [SLOT_W-1:0] self;    // slot or UNREG_SLOT
    } cfg_t;

    // Request after classification
    typedef struct packed {
        kind_t             kind;
        logic [TERM_W-1:0] term;
        logic [SLOT_W-1:0] cand;      // normalized candidate slot
        logic [4:0]        voter;
        logic              voter_ok;  // voter slot below follower count
    } item_t;

    // Number of set bits in a 32-bit mask
    function automatic logic [SLOT_W-1:0] popcount32(input logic [MAX_FOLLOWERS-1:0] v);
        logic [SLOT_W-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_FOLLOWERS; i++) begin
            c = c + SLOT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

@@ rtl/qle_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qle_front - request classifier
// Decodes the input stream into a request kind and normalized slots.
// ----------------------------------------------------------------------------
module qle_front (
    input  qle_pkg::cfg_t                         cfg,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [qle_pkg::S_DATA_W-1:0]          s_tdata,
    input  logic                                  s_tuser,
    output logic                                  push,
    output qle_pkg::item_t                        push_item,
    input  logic                                  push_ready
);
    import qle_pkg::*;

    logic              healthy;
    logic [SLOT_W-1:0] cand_raw;
    logic [SLOT_W-1:0] voter_raw;

    assign healthy   = s_tdata[0];
    assign cand_raw  = s_tdata[37:32];
    assign voter_raw = s_tdata[43:38];

    assign s_tready = push_ready;
    assign push     = s_tvalid & push_ready;

    // Classify the request, fold an out-of-range candidate slot and flag the voter slot
    always_comb begin
        if (s_tuser == REQ_BALLOT) begin
            push_item.kind = KIND_BALLOT;
        end else if (healthy) begin
            push_item.kind = KIND_TICK_HEALTHY;
        end else begin
            push_item.kind = KIND_TICK_FAILED;
        end
        push_item.term     = s_tdata[31:1];
        push_item.cand     = (cand_raw < cfg.count) ? cand_raw : UNREG_SLOT;
        push_item.voter    = voter_raw[4:0];
        push_item.voter_ok = (voter_raw < cfg.count);
    end

endmodule

@@ rtl/qle_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qle_queue - two-entry request queue
// Decouples the classifier from the election engine.
// ----------------------------------------------------------------------------
module qle_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  qle_pkg::item_t   in_item,
    output logic             in_ready,
    output logic             out_valid,
    output qle_pkg::item_t   out_item,
    input  logic             out_pop
);
    import qle_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign do_push   = in_valid & in_ready;
    assign do_pop    = out_pop & out_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/qle_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qle_back - election engine
// Holds the election state, applies one request per cycle while the result
// register is free or taken, and registers the result for the output stream.
// ----------------------------------------------------------------------------
module qle_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  qle_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  qle_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [qle_pkg::M_DATA_W-1:0]  m_tdata
);
    import qle_pkg::*;

    logic [TERM_W-1:0]        term_reg,      term_next;
    logic [SLOT_W-1:0]        cand_reg,      cand_next;
    logic                     cand_held_reg, cand_held_next;
    logic [MAX_FOLLOWERS-1:0] vote_mask_reg, vote_mask_next;
    logic [MAX_FOLLOWERS-1:0] dead_mask_reg, dead_mask_next;
    logic [SLOT_W-1:0]        leader_reg,    leader_next;
    logic                     leader_held_reg, leader_held_next;
    logic                     promoted_reg,  promoted_next;

    logic                     out_valid_reg;
    logic [M_DATA_W-1:0]      out_data_reg, out_data_next;

    logic                     self_reg_ok;
    logic [MAX_FOLLOWERS-1:0] self_bit;
    logic [SLOT_W-1:0]        votes;
    logic                     check, quorum, changed, accepted, send;

    assign q_pop       = q_valid & (~out_valid_reg | m_tready);
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign self_reg_ok = (cfg.self != UNREG_SLOT);
    assign self_bit    = self_reg_ok ? (MAX_FOLLOWERS'(1) << cfg.self[4:0]) : '0;

    // Next election state for the request at the queue head
    always_comb begin
        logic [MAX_FOLLOWERS-1:0] live;
        logic [SLOT_W-1:0]        nominee;
        logic                     found;

        term_next        = term_reg;
        cand_next        = cand_reg;
        cand_held_next   = cand_held_reg;
        vote_mask_next   = vote_mask_reg;
        dead_mask_next   = dead_mask_reg;
        leader_next      = leader_reg;
        leader_held_next = leader_held_reg;
        promoted_next    = promoted_reg;
        check            = 1'b0;
        accepted         = 1'b0;
        send             = 1'b0;
        live             = '0;
        nominee          = '0;
        found            = 1'b0;

        case (q_item.kind)
            KIND_TICK_HEALTHY: begin
                if (!promoted_reg) begin
                    cand_held_next = 1'b0;
                    cand_next      = '0;
                    vote_mask_next = '0;
                end
            end
            KIND_TICK_FAILED: begin
                if (!promoted_reg) begin
                    // Blacklist the failed leader
                    if (leader_held_reg) begin
                        if (leader_reg < cfg.count) begin
                            dead_mask_next[leader_reg[4:0]] = 1'b1;
                        end
                        leader_held_next = 1'b0;
                        leader_next      = '0;
                    end
                    // Lowest live slot is the nominee
                    for (int i = 0; i < MAX_FOLLOWERS; i++) begin
                        live[i] = ~dead_mask_next[i] & (SLOT_W'(i) < cfg.count);
                    end
                    for (int i = 0; i < MAX_FOLLOWERS; i++) begin
                        if (live[i] && !found) begin
                            nominee = SLOT_W'(i);
                            found   = 1'b1;
                        end
                    end
                    // New nominee opens a new term
                    if (!cand_held_reg || cand_reg != nominee) begin
                        if (term_reg != TERM_MAX) begin
                            term_next = term_reg + TERM_W'(1);
                        end
                        cand_next      = nominee;
                        cand_held_next = 1'b1;
                        vote_mask_next = '0;
                    end
                    vote_mask_next = vote_mask_next | self_bit;
                    check = 1'b1;
                    send  = ~self_reg_ok | (cfg.count > SLOT_W'(1));
                end
            end
            KIND_BALLOT: begin
                if (q_item.term > term_reg) begin
                    term_next      = q_item.term;
                    cand_next      = q_item.cand;
                    cand_held_next = 1'b1;
                    vote_mask_next = '0;
                end else if (q_item.term == term_reg && !cand_held_reg) begin
                    cand_next      = q_item.cand;
                    cand_held_next = 1'b1;
                end
                if (q_item.term == term_next && cand_held_next && q_item.cand == cand_next) begin
                    accepted = 1'b1;
                    if (q_item.voter_ok) begin
                        vote_mask_next[q_item.voter] = 1'b1;
                    end
                    check = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Majority check and leader confirmation
        votes   = popcount32(vote_mask_next);
        quorum  = check & cand_held_next & (votes >= (cfg.count >> 1) + SLOT_W'(1));
        changed = 1'b0;
        if (quorum) begin
            if (!leader_held_next || leader_next != cand_next) begin
                leader_next      = cand_next;
                leader_held_next = 1'b1;
                changed          = ~self_reg_ok | (cand_next != cfg.self);
            end
            if (self_reg_ok && cand_next == cfg.self) begin
                promoted_next = 1'b1;
            end
        end

        out_data_next = {send, accepted, promoted_next, changed,
                         leader_held_next ? leader_next : SLOT_W'(0),
                         leader_held_next, quorum, votes, cand_held_next,
                         cand_held_next ? cand_next : SLOT_W'(0),
                         term_next};
    end

    // Election state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg        <= '0;
            cand_reg        <= '0;
            cand_held_reg   <= 1'b0;
            vote_mask_reg   <= '0;
            dead_mask_reg   <= '0;
            leader_reg      <= '0;
            leader_held_reg <= 1'b0;
            promoted_reg    <= 1'b0;
        end else if (q_pop) begin
            term_reg        <= term_next;
            cand_reg        <= cand_next;
            cand_held_reg   <= cand_held_next;
            vote_mask_reg   <= vote_mask_next;
            dead_mask_reg   <= dead_mask_next;
            leader_reg      <= leader_next;
            leader_held_reg <= leader_held_next;
            promoted_reg    <= promoted_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ rtl/quorum_leader_election.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quorum_leader_election - quorum based leader election engine
// Tracks term, candidate, votes, blacklist and leader over 32 follower slots.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_tuser = 0 for a health tick, 1 for a ballot.
//   m_* returns exactly one result per request, in request order.
//   cfg_we/cfg_index/cfg_data write follower_count (index 0) and
//   self_index (index 1); write them only while no request is in flight.
// Path: a request accepted on s_* is written into the two-entry queue and,
//   when nothing waits ahead of it, is applied from the queue head into the
//   result register, which drives m_*.
// Throughput: one request per cycle while m_* does not stall, each applied
//   in a single pass (nominee search, vote popcount, majority compare).
// Reset: synchronous, aresetn low. Clears all election state, the queue and
//   the output valid; follower_count returns to 1 and self_index to 32.
// Stall: while m_tready is low the result is held; up to two more requests
//   are queued, then s_tready drops until the receiver takes the result.
// ----------------------------------------------------------------------------
module quorum_leader_election (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [qle_pkg::SLOT_W-1:0]     cfg_data,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] primary_healthy, [31:1] vote_term, [37:32] vote_candidate,
    // [43:38] vote_voter, [47:44] zero
    input  logic [qle_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] req_type
    input  logic                           s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [30:0] cur_term, [36:31] cur_candidate, [37] candidate_valid,
    // [43:38] vote_count, [44] quorum_reached, [45] leader_valid,
    // [51:46] leader_index, [52] leader_changed, [53] promoted,
    // [54] ballot_accepted, [55] send_ballot
    output logic [qle_pkg::M_DATA_W-1:0]   m_tdata
);
    import qle_pkg::*;

    logic [SLOT_W-1:0] follower_count_reg;
    logic [SLOT_W-1:0] self_index_reg;
    cfg_t              cfg;
    logic              push, push_ready;
    item_t             push_item;
    logic              q_valid, q_pop;
    item_t             q_item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            follower_count_reg <= SLOT_W'(1);
            self_index_reg     <= UNREG_SLOT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FOLLOWER_COUNT: follower_count_reg <= cfg_data;
                REG_SELF_INDEX:     self_index_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the count and fold an out-of-range self slot
    always_comb begin
        if (follower_count_reg == '0) begin
            cfg.count = SLOT_W'(1);
        end else if (follower_count_reg > MAX_COUNT) begin
            cfg.count = MAX_COUNT;
        end else begin
            cfg.count = follower_count_reg;
        end
        cfg.self = (self_index_reg < cfg.count) ? self_index_reg : UNREG_SLOT;
    end

    qle_front u_front (
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    qle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_item   (push_item),
        .in_ready  (push_ready),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_pop   (q_pop)
    );

    qle_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
